/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check the consequent in the same cycle as the antecedent
`define CGR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// check the consequent in the cycle after the antecedent
`define CGR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/cgr_pkg.sv */
// ----------------------------------------------------------------------------
// cgr_pkg
// Types, codes and bit-search helpers for the chordal graph recognizer.
// ----------------------------------------------------------------------------
`default_nettype none

package cgr_pkg;

  localparam int MAX_NODES = 64;
  localparam int IDW       = $clog2(MAX_NODES);
  localparam int CNTW      = $clog2(MAX_NODES + 1);

  typedef logic [MAX_NODES-1:0] row_t;
  typedef logic [IDW-1:0]       id_t;
  typedef logic [CNTW-1:0]      cnt_t;

  localparam logic [1:0] MODE_EDGE  = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_RUN   = 2'd2;

  typedef enum logic [5:0] {
    OP_NONE, OP_CLEAR, OP_ED_RDA, OP_ED_WRA, OP_ED_WRB,
    OP_INIT, OP_INIT_WR, OP_POP_RD, OP_POP_X, OP_POP_ROW,
    OP_CLS_BEGIN, OP_SWP_RD, OP_SWP_CAP, OP_NB_LOAD, OP_NB_EMIT,
    OP_NN_BEGIN, OP_NN_RD, OP_NN_CAP, OP_SWAP,
    OP_FB_INIT, OP_FB_VRD, OP_FB_VCAP, OP_FB_ROW, OP_FB_QRD, OP_FB_QCAP, OP_FB_WR,
    OP_MG_RD, OP_MG_LOW, OP_MG_SKIP, OP_MG_MRG,
    OP_EM_RD, OP_EM_CAP, OP_EM_NEXT
  } op_t;

  typedef struct packed {
    logic edge_ok;
    logic swp_last;
    logic nn_last;
    logic all_end;
    logic e_zero;
    logic r_one;
    logic p_last;
    logic q_last;
    logic mg_last;
    logic n_one;
    logic frow_zero;
    logic out_take;
    logic out_last;
  } status_t;

  function automatic id_t highest_bit(input row_t r);
    id_t h;
    h = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (r[i]) h = id_t'(i);
    end
    return h;
  endfunction

  function automatic id_t lowest_bit(input row_t r);
    id_t h;
    h = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (r[i]) h = id_t'(i);
    end
    return h;
  endfunction

endpackage

`default_nettype wire

/* src/cgr_dp.sv */
// ----------------------------------------------------------------------------
// cgr_dp
// Datapath: adjacency store, partition sequence banks, ordering and fill
// rows, counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cgr_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cgr_pkg::op_t  op,
  output cgr_pkg::status_t   status,
  input  wire logic          cfg_write,
  input  wire logic [6:0]    cfg_data,
  input  wire logic [5:0]    node_a,
  input  wire logic [5:0]    node_b,
  output logic               result_valid,
  input  wire logic          result_stall,
  output logic [5:0]         vertex,
  output logic [6:0]         position,
  output logic               chordal,
  output logic               last
);
  import cgr_pkg::*;

  cnt_t node_count;
  cnt_t n;

  // adjacency rows, a row reads as zero until written since the last clear
  row_t adj [MAX_NODES];
  row_t adj_vld;
  row_t adj_q;
  logic adj_vq;
  row_t adj_row;
  id_t  adj_ra, adj_wa;
  row_t adj_wd;
  logic adj_we;

  id_t  seq0 [MAX_NODES];
  id_t  seq1 [MAX_NODES];
  id_t  seq0_q, seq1_q, seq_q;
  id_t  seq_ra, seq_wa, seq_wd;
  logic seq_we0, seq_we1;
  logic bank;

  id_t  vat [MAX_NODES];
  id_t  vat_q, vat_ra, vat_wa;
  logic vat_we;

  row_t frow [MAX_NODES];
  row_t frow_q, frow_wd;
  id_t  frow_ra, frow_wa;
  logic frow_we;

  cnt_t r_cnt, rd;
  id_t  a, wr, rd2, p, q, k, ea, eb, hi;
  row_t st, nst, mset, eset, nrow, acc, rowv, tmerge;
  logic first, chord;
  cnt_t rd_inc;

  always_comb begin
    n = node_count;
    if (node_count == '0) n = cnt_t'(1);
    if (node_count > cnt_t'(MAX_NODES)) n = cnt_t'(MAX_NODES);
  end

  assign adj_row = adj_vq ? adj_q : '0;
  assign seq_q   = bank ? seq1_q : seq0_q;
  assign hi      = highest_bit(eset);
  assign tmerge  = rowv & ~(row_t'(1) << k);
  assign rd_inc  = rd + cnt_t'(1);

  always_comb begin
    adj_ra = ea; adj_wa = ea; adj_wd = adj_row | (row_t'(1) << eb); adj_we = 1'b0;
    seq_ra = '0; seq_wa = wr; seq_wd = hi; seq_we0 = 1'b0; seq_we1 = 1'b0;
    vat_ra = p; vat_wa = id_t'(r_cnt - cnt_t'(1)); vat_we = 1'b0;
    frow_ra = p; frow_wa = p; frow_wd = acc; frow_we = 1'b0;
    case (op)
      OP_ED_RDA: adj_ra = node_a;
      OP_ED_WRA: begin
        adj_we = 1'b1;
        adj_ra = eb;
      end
      OP_ED_WRB: begin
        adj_we = 1'b1;
        adj_wa = eb;
        adj_wd = adj_row | (row_t'(1) << ea);
      end
      OP_INIT_WR: begin
        seq_wa = p;
        seq_wd = id_t'(n - cnt_t'(1) - cnt_t'({1'b0, p}));
        seq_we0 = ~bank;
        seq_we1 = bank;
      end
      OP_POP_RD: seq_ra = '0;
      OP_POP_X: begin
        vat_we = 1'b1;
        adj_ra = seq_q;
      end
      OP_SWP_RD: seq_ra = rd[IDW-1:0];
      OP_NB_EMIT: begin
        seq_we0 = bank & (eset != '0);
        seq_we1 = ~bank & (eset != '0);
      end
      OP_NN_RD: seq_ra = rd2;
      OP_NN_CAP: begin
        seq_wd = seq_q;
        seq_we0 = bank & ~nrow[seq_q];
        seq_we1 = ~bank & ~nrow[seq_q];
      end
      OP_FB_VRD: vat_ra = p;
      OP_FB_VCAP: adj_ra = vat_q;
      OP_FB_QRD: vat_ra = q;
      OP_FB_WR: frow_we = 1'b1;
      OP_MG_RD: frow_ra = p;
      OP_MG_LOW: frow_ra = lowest_bit(frow_q);
      OP_MG_MRG: begin
        frow_we = 1'b1;
        frow_wa = k;
        frow_wd = frow_q | tmerge;
      end
      OP_EM_RD: vat_ra = id_t'(r_cnt - cnt_t'(1));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adj_we) adj[adj_wa] <= adj_wd;
    adj_q  <= adj[adj_ra];
    adj_vq <= adj_vld[adj_ra];
  end

  always_ff @(posedge clk) begin
    if (seq_we0) seq0[seq_wa] <= seq_wd;
    seq0_q <= seq0[seq_ra];
  end

  always_ff @(posedge clk) begin
    if (seq_we1) seq1[seq_wa] <= seq_wd;
    seq1_q <= seq1[seq_ra];
  end

  always_ff @(posedge clk) begin
    if (vat_we) vat[vat_wa] <= seq_q;
    vat_q <= vat[vat_ra];
  end

  always_ff @(posedge clk) begin
    if (frow_we) frow[frow_wa] <= frow_wd;
    frow_q <= frow[frow_ra];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count   <= cnt_t'(MAX_NODES);
      adj_vld      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) node_count <= cfg_data;
      if (op == OP_CLEAR) adj_vld <= '0;
      if (adj_we) adj_vld[adj_wa] <= 1'b1;
      if (op == OP_EM_CAP) result_valid <= 1'b1;
      if (op == OP_EM_NEXT) result_valid <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (op)
      OP_ED_RDA: begin
        ea <= node_a;
        eb <= node_b;
      end
      OP_INIT: begin
        r_cnt <= n;
        p     <= '0;
        st    <= row_t'(1);
        bank  <= 1'b0;
      end
      OP_INIT_WR: p <= p + id_t'(1);
      OP_POP_ROW: begin
        nrow <= adj_row;
        rd   <= cnt_t'(1);
        wr   <= '0;
        nst  <= '0;
      end
      OP_CLS_BEGIN: begin
        a    <= rd[IDW-1:0];
        mset <= '0;
      end
      OP_SWP_CAP: begin
        mset[seq_q] <= 1'b1;
        rd <= rd_inc;
      end
      OP_NB_LOAD: begin
        eset  <= mset & nrow;
        first <= 1'b1;
      end
      OP_NB_EMIT: begin
        if (eset != '0) begin
          eset[hi] <= 1'b0;
          if (first) nst[wr] <= 1'b1;
          first <= 1'b0;
          wr <= wr + id_t'(1);
        end
      end
      OP_NN_BEGIN: begin
        rd2   <= a;
        first <= 1'b1;
      end
      OP_NN_CAP: begin
        if (!nrow[seq_q]) begin
          if (first) nst[wr] <= 1'b1;
          first <= 1'b0;
          wr <= wr + id_t'(1);
        end
        rd2 <= rd2 + id_t'(1);
      end
      OP_SWAP: begin
        bank  <= ~bank;
        st    <= nst;
        r_cnt <= r_cnt - cnt_t'(1);
      end
      OP_FB_INIT: begin
        p     <= '0;
        chord <= 1'b1;
        r_cnt <= n;
      end
      OP_FB_ROW: begin
        nrow <= adj_row;
        acc  <= '0;
        q    <= p + id_t'(1);
      end
      OP_FB_QCAP: begin
        acc[q] <= nrow[vat_q];
        q <= q + id_t'(1);
      end
      OP_FB_WR: p <= status.p_last ? '0 : p + id_t'(1);
      OP_MG_LOW: begin
        rowv <= frow_q;
        k    <= lowest_bit(frow_q);
      end
      OP_MG_SKIP: p <= p + id_t'(1);
      OP_MG_MRG: begin
        // any bit new to the earliest neighbor's row is a fill edge
        if ((tmerge & ~frow_q) != '0) chord <= 1'b0;
        p <= p + id_t'(1);
      end
      OP_EM_CAP: begin
        vertex   <= vat_q;
        position <= r_cnt;
        chordal  <= chord;
        last     <= (r_cnt == cnt_t'(1));
      end
      OP_EM_NEXT: r_cnt <= r_cnt - cnt_t'(1);
      default: ;
    endcase
  end

  always_comb begin
    status.edge_ok   = (node_a != node_b) && (cnt_t'({1'b0, node_a}) < n)
                       && (cnt_t'({1'b0, node_b}) < n);
    status.swp_last  = (rd_inc == r_cnt) || st[rd_inc[IDW-1:0]];
    status.nn_last   = (cnt_t'({1'b0, rd2}) + cnt_t'(1)) == rd;
    status.all_end   = (rd == r_cnt);
    status.e_zero    = (eset == '0);
    status.r_one     = (r_cnt == cnt_t'(1));
    status.p_last    = (cnt_t'({1'b0, p}) + cnt_t'(1)) == n;
    status.q_last    = (cnt_t'({1'b0, q}) + cnt_t'(1)) == n;
    status.mg_last   = (cnt_t'({1'b0, p}) + cnt_t'(2)) == n;
    status.n_one     = (n == cnt_t'(1));
    status.frow_zero = (frow_q == '0);
    status.out_take  = result_valid && !result_stall;
    status.out_last  = last;
  end

endmodule

`default_nettype wire

/* src/cgr_ctrl.sv */
// ----------------------------------------------------------------------------
// cgr_ctrl
// Sequencer: decodes commands and steps the datapath through edge load,
// ordering, fill-in test and result output.
// ----------------------------------------------------------------------------
`default_nettype none

module cgr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire logic [1:0]        mode,
  input  wire cgr_pkg::status_t  status,
  output cgr_pkg::op_t           op
);
  import cgr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_ED_A, S_ED_B, S_INIT_WR, S_POP_RD, S_POP_X, S_POP_ROW,
    S_CLS, S_SWP_RD, S_SWP_CAP, S_NB_LOAD, S_NB, S_NN_RD, S_NN_CAP, S_SWAP,
    S_FB_INIT, S_FB_VRD, S_FB_VCAP, S_FB_ROW, S_FB_QRD, S_FB_QCAP, S_FB_WR,
    S_MG_RD, S_MG_LOW, S_MG_MRG, S_EM_RD, S_EM_CAP, S_EM_WAIT
  } state_t;

  state_t state, state_next;

  assign item_stall = (state != S_IDLE);

  always_comb begin
    op = OP_NONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          case (mode)
            MODE_EDGE: begin
              if (status.edge_ok) begin
                op = OP_ED_RDA;
                state_next = S_ED_A;
              end
            end
            MODE_CLEAR: op = OP_CLEAR;
            MODE_RUN: begin
              op = OP_INIT;
              state_next = S_INIT_WR;
            end
            default: ;
          endcase
        end
      end
      S_ED_A: begin
        op = OP_ED_WRA;
        state_next = S_ED_B;
      end
      S_ED_B: begin
        op = OP_ED_WRB;
        state_next = S_IDLE;
      end
      S_INIT_WR: begin
        op = OP_INIT_WR;
        if (status.p_last) state_next = S_POP_RD;
      end
      S_POP_RD: begin
        op = OP_POP_RD;
        state_next = S_POP_X;
      end
      S_POP_X: begin
        op = OP_POP_X;
        state_next = S_POP_ROW;
      end
      S_POP_ROW: begin
        op = OP_POP_ROW;
        state_next = status.r_one ? S_FB_INIT : S_CLS;
      end
      S_CLS: begin
        op = OP_CLS_BEGIN;
        state_next = S_SWP_RD;
      end
      S_SWP_RD: begin
        op = OP_SWP_RD;
        state_next = S_SWP_CAP;
      end
      S_SWP_CAP: begin
        op = OP_SWP_CAP;
        state_next = status.swp_last ? S_NB_LOAD : S_SWP_RD;
      end
      S_NB_LOAD: begin
        op = OP_NB_LOAD;
        state_next = S_NB;
      end
      S_NB: begin
        // neighbors go out highest id first, then the rest in order
        if (status.e_zero) begin
          op = OP_NN_BEGIN;
          state_next = S_NN_RD;
        end else begin
          op = OP_NB_EMIT;
        end
      end
      S_NN_RD: begin
        op = OP_NN_RD;
        state_next = S_NN_CAP;
      end
      S_NN_CAP: begin
        op = OP_NN_CAP;
        if (status.nn_last) state_next = status.all_end ? S_SWAP : S_CLS;
        else state_next = S_NN_RD;
      end
      S_SWAP: begin
        op = OP_SWAP;
        state_next = S_POP_RD;
      end
      S_FB_INIT: begin
        op = OP_FB_INIT;
        state_next = S_FB_VRD;
      end
      S_FB_VRD: begin
        op = OP_FB_VRD;
        state_next = S_FB_VCAP;
      end
      S_FB_VCAP: begin
        op = OP_FB_VCAP;
        state_next = S_FB_ROW;
      end
      S_FB_ROW: begin
        op = OP_FB_ROW;
        state_next = status.p_last ? S_FB_WR : S_FB_QRD;
      end
      S_FB_QRD: begin
        op = OP_FB_QRD;
        state_next = S_FB_QCAP;
      end
      S_FB_QCAP: begin
        op = OP_FB_QCAP;
        state_next = status.q_last ? S_FB_WR : S_FB_QRD;
      end
      S_FB_WR: begin
        op = OP_FB_WR;
        if (status.p_last) state_next = status.n_one ? S_EM_RD : S_MG_RD;
        else state_next = S_FB_VRD;
      end
      S_MG_RD: begin
        op = OP_MG_RD;
        state_next = S_MG_LOW;
      end
      S_MG_LOW: begin
        if (status.frow_zero) begin
          op = OP_MG_SKIP;
          state_next = status.mg_last ? S_EM_RD : S_MG_RD;
        end else begin
          op = OP_MG_LOW;
          state_next = S_MG_MRG;
        end
      end
      S_MG_MRG: begin
        op = OP_MG_MRG;
        state_next = status.mg_last ? S_EM_RD : S_MG_RD;
      end
      S_EM_RD: begin
        op = OP_EM_RD;
        state_next = S_EM_CAP;
      end
      S_EM_CAP: begin
        op = OP_EM_CAP;
        state_next = S_EM_WAIT;
      end
      S_EM_WAIT: begin
        if (status.out_take) begin
          op = OP_EM_NEXT;
          state_next = status.out_last ? S_IDLE : S_EM_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* src/chordal_graph_recognition.sv */
// ----------------------------------------------------------------------------
// chordal_graph_recognition
// Loads an undirected graph, orders it by lexicographic BFS and tests it
// for chordality, streaming the ordering with the verdict.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (item_valid/item_stall): mode 0 adds edge node_a-node_b,
//   mode 1 clears the graph, mode 2 runs. Self-loops and endpoints at or
//   above node_count are dropped. item_stall is high whenever a command
//   is in progress.
//   An edge load is a read-modify-write of two adjacency rows through one
//   memory port; a clear resets the row valid flags.
//   A run orders the vertices (each step sweeps the remaining sequence
//   twice with a registered memory read per element), then builds the
//   fill rows, runs the merge pass and streams the result words.
//   Result words (result_valid/result_stall): one per vertex, position n
//   first, last set on position 1. A stalled word holds until taken.
//   cfg_write loads node_count; the user must write it only while the
//   block is idle, since the block itself does not enforce this.
//   Reset: graph empty, node_count 64, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module chordal_graph_recognition (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [6:0] cfg_data,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic [1:0] mode,
  input  wire logic [5:0] node_a,
  input  wire logic [5:0] node_b,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic [5:0]      vertex,
  output logic [6:0]      position,
  output logic            chordal,
  output logic            last
);
  import cgr_pkg::*;

  op_t     op;
  status_t status;

  cgr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .mode       (mode),
    .status     (status),
    .op         (op)
  );

  cgr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .node_a       (node_a),
    .node_b       (node_b),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .vertex       (vertex),
    .position     (position),
    .chordal      (chordal),
    .last         (last)
  );

`include "assert_macros.svh"

  `CGR_ASSERT_SAME(a_no_intake, clk, rst, result_valid, item_stall, "word taken during output")
  `CGR_ASSERT_SAME(a_last_pos, clk, rst, result_valid && last, position == 7'd1, "last off pos 1")
  `CGR_ASSERT_NEXT(a_run_busy, clk, rst, item_valid && !item_stall && mode == MODE_RUN, item_stall, "run not started")
  `CGR_ASSERT_NEXT(a_take_drop, clk, rst, result_valid && !result_stall, !result_valid, "result repeated")

endmodule

`default_nettype wire

/* sim/chordal_graph_recognition_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chordal_graph_recognition_tb
// Loads graphs edge by edge and runs the recognizer under random handshake
// gaps. A scoreboard predicts the LexBFS ordering and the chordal verdict
// of every run and checks each result word against it in order.
// ----------------------------------------------------------------------------
`default_nettype none

module chordal_graph_recognition_tb;
  import cgr_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int NIL = MAX_NODES + 1;

  typedef struct {
    logic [5:0] vertex;
    logic [6:0] position;
    logic       chordal;
    logic       last;
  } order_word_t;

  class chordal_scoreboard;
    logic [63:0] adj [64];
    int unsigned node_count;
    order_word_t pending [$];
    int errors;
    int cprev [65], cnext [65], chead [65], csplit [65];
    int vprev [64], vnext [64], vcls [64];
    int fstack [66];
    int ftop, first;

    function new();
      node_count = 64;
      errors = 0;
      foreach (adj[i]) adj[i] = '0;
    endfunction

    function int active_n();
      if (node_count < 1) return 1;
      if (node_count > MAX_NODES) return MAX_NODES;
      return node_count;
    endfunction

    function void unlink_v(int v, int s);
      int p, q;
      p = vprev[v];
      q = vnext[v];
      if (p != NIL) vnext[p] = q; else chead[s] = q;
      if (q != NIL) vprev[q] = p;
      vprev[v] = NIL;
      vnext[v] = NIL;
    endfunction

    function void link_v(int v, int s);
      int h;
      h = chead[s];
      vcls[v] = s;
      vprev[v] = NIL;
      vnext[v] = h;
      if (h != NIL) vprev[h] = v;
      chead[s] = v;
    endfunction

    function void drop_c(int s);
      int p, q;
      p = cprev[s];
      q = cnext[s];
      if (p != NIL) cnext[p] = q; else first = q;
      if (q != NIL) cprev[q] = p;
      if (ftop < MAX_NODES + 1) begin
        fstack[ftop] = s;
        ftop++;
      end
    endfunction

    function void refine(int w);
      int s, t, p;
      s = vcls[w];
      if (s > MAX_NODES) return;
      t = csplit[s];
      if (t == NIL) begin
        if (ftop == 0) return;
        ftop--;
        t = fstack[ftop];
        p = cprev[s];
        cprev[t] = p;
        cnext[t] = s;
        chead[t] = NIL;
        csplit[t] = NIL;
        cprev[s] = t;
        if (p != NIL) cnext[p] = t; else first = t;
        csplit[s] = t;
      end
      unlink_v(w, s);
      link_v(w, t);
      if (chead[s] == NIL) drop_c(s);
    endfunction

    // order the vertices, run the zero fill-in test and queue the words
    function void predict_run();
      int n, c, x, popped, original, gstar, k, m, v;
      int pos [64], at [64], order [64];
      logic [63:0] fill [64];
      order_word_t wd;
      n = active_n();
      popped = 0;
      original = 0;
      gstar = 0;
      for (int s = 0; s <= MAX_NODES; s++) begin
        cprev[s] = NIL; cnext[s] = NIL; chead[s] = NIL; csplit[s] = NIL;
      end
      ftop = 0;
      for (int s = n; s >= 2; s--) begin
        fstack[ftop] = s;
        ftop++;
      end
      first = 1;
      for (int i = 0; i < n; i++) link_v(i, 1);
      for (int i = n; i >= 1; i--) begin
        c = first;
        if (c > MAX_NODES) break;
        x = chead[c];
        if (x >= MAX_NODES) break;
        unlink_v(x, c);
        vcls[x] = NIL;
        if (chead[c] == NIL) drop_c(c);
        pos[x] = i;
        at[i-1] = x;
        order[popped] = x;
        popped++;
        for (int w = 0; w < n; w++)
          if (adj[x][w] && vcls[w] != NIL) refine(w);
        for (int s = 0; s <= MAX_NODES; s++) csplit[s] = NIL;
      end
      for (int i = 0; i < n; i++) begin
        fill[i] = '0;
        for (int w = 0; w < n; w++)
          if (adj[i][w] && pos[i] < pos[w]) begin
            fill[i][w] = 1'b1;
            original++;
          end
      end
      for (int i = 1; i < n; i++) begin
        v = at[i-1];
        k = n;
        for (int w = 0; w < n; w++)
          if (fill[v][w]) begin
            gstar++;
            if (pos[w] < k) k = pos[w];
          end
        if (k < 1 || k > n) continue;
        m = at[k-1];
        for (int w = 0; w < n; w++)
          if (fill[v][w] && w != m) fill[m][w] = 1'b1;
      end
      for (int i = 0; i < popped; i++) begin
        wd.vertex   = order[i][5:0];
        wd.position = pos[order[i]][6:0];
        wd.chordal  = (gstar == original);
        wd.last     = (i + 1 == popped);
        pending.insert(pending.size(), wd);
      end
    endfunction

    function void note_word(logic [1:0] md, logic [5:0] a, logic [5:0] b);
      int n;
      n = active_n();
      case (md)
        MODE_EDGE: begin
          if (a != b && a < n && b < n) begin
            adj[a][b] = 1'b1;
            adj[b][a] = 1'b1;
          end
        end
        MODE_CLEAR: foreach (adj[i]) adj[i] = '0;
        MODE_RUN: predict_run();
        default: ;
      endcase
    endfunction

    function void check_word(logic [5:0] vx, logic [6:0] ps, logic ch, logic lst);
      order_word_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word vertex %0d position %0d", $time, vx, ps);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (vx !== e.vertex) begin
        $display("%0t: vertex expected %0d actual %0d", $time, e.vertex, vx);
        errors++;
      end
      if (ps !== e.position) begin
        $display("%0t: position expected %0d actual %0d", $time, e.position, ps);
        errors++;
      end
      if (ch !== e.chordal) begin
        $display("%0t: chordal expected %0d actual %0d", $time, e.chordal, ch);
        errors++;
      end
      if (lst !== e.last) begin
        $display("%0t: last expected %0d actual %0d", $time, e.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [6:0] cfg_data;
  logic       item_valid;
  logic       item_stall;
  logic [1:0] mode;
  logic [5:0] node_a;
  logic [5:0] node_b;
  logic       result_valid;
  logic       result_stall;
  logic [5:0] vertex;
  logic [6:0] position;
  logic       chordal;
  logic       last;

  chordal_scoreboard sb;
  bit idle_on;
  bit hold_req;

  chordal_graph_recognition DUT (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .mode(mode), .node_a(node_a), .node_b(node_b),
    .result_valid(result_valid), .result_stall(result_stall),
    .vertex(vertex), .position(position), .chordal(chordal), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_word(vertex, position, chordal, last);
  end

  // receiver: random stalls per word, one long hold on request
  initial begin
    int w;
    result_stall = 1'b1;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end
      w = idle_on ? $urandom_range(0, 8) : 0;
      if (w > 0) begin
        result_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  task automatic send_word(logic [1:0] md, logic [5:0] a, logic [5:0] b);
    int w;
    w = idle_on ? $urandom_range(0, 8) : 0;
    if (w > 0) begin
      item_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    item_valid <= 1'b1;
    mode   <= md;
    node_a <= a;
    node_b <= b;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_word(md, a, b);
  endtask

  // drain all results, let any edge load finish, then write node_count
  task automatic set_count(logic [6:0] v);
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.node_count = v;
  endtask

  task automatic random_graph(int n, int budget);
    int sent, edges;
    sent = 0;
    if ($urandom_range(0, 2) == 0) begin
      send_word(MODE_CLEAR, 6'($urandom), 6'($urandom));
      sent++;
    end
    while (sent < budget) begin
      edges = $urandom_range(0, (2 * n > 40) ? 40 : 2 * n);
      for (int e = 0; e < edges && sent < budget - 1; e++) begin
        if ($urandom_range(0, 9) == 0)
          send_word(MODE_EDGE, 6'($urandom), 6'($urandom));
        else if ($urandom_range(0, 29) == 0)
          send_word(MODE_SPARE, 6'($urandom), 6'($urandom));
        else
          send_word(MODE_EDGE, 6'($urandom_range(0, n - 1)), 6'($urandom_range(0, n - 1)));
        sent++;
      end
      send_word(MODE_RUN, 6'($urandom), 6'($urandom));
      sent++;
      if ($urandom_range(0, 3) == 0) begin
        send_word(MODE_CLEAR, 6'd0, 6'd0);
        sent++;
      end
    end
  endtask

  initial begin
    int n;
    sb = new();
    idle_on = 1'b1;
    hold_req = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    item_valid = 1'b0;
    mode = MODE_EDGE;
    node_a = '0;
    node_b = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full size: extreme ids, self-loop, spare mode, short path
    send_word(MODE_EDGE, 6'd0, 6'd63);
    send_word(MODE_EDGE, 6'd63, 6'd62);
    send_word(MODE_EDGE, 6'd17, 6'd17);
    send_word(MODE_SPARE, 6'd63, 6'd63);
    send_word(MODE_RUN, 6'd0, 6'd0);
    send_word(MODE_CLEAR, 6'd63, 6'd0);
    send_word(MODE_RUN, 6'd0, 6'd0);

    // single vertex, and zero acting as one
    set_count(7'd1);
    send_word(MODE_EDGE, 6'd0, 6'd1);
    send_word(MODE_RUN, 6'd0, 6'd0);
    set_count(7'd0);
    send_word(MODE_RUN, 6'd0, 6'd0);

    // the square 0-1-2-3 is not chordal; add a chord and it is
    set_count(7'd4);
    send_word(MODE_EDGE, 6'd0, 6'd1);
    send_word(MODE_EDGE, 6'd1, 6'd2);
    send_word(MODE_EDGE, 6'd2, 6'd3);
    send_word(MODE_EDGE, 6'd3, 6'd0);
    send_word(MODE_EDGE, 6'd0, 6'd5);
    send_word(MODE_RUN, 6'd0, 6'd0);
    send_word(MODE_EDGE, 6'd0, 6'd2);
    send_word(MODE_RUN, 6'd0, 6'd0);

    // edges above a lowered count drop out of the run
    set_count(7'd8);
    send_word(MODE_EDGE, 6'd7, 6'd1);
    send_word(MODE_EDGE, 6'd6, 6'd3);
    set_count(7'd5);
    send_word(MODE_RUN, 6'd0, 6'd0);

    // above the maximum acts as the maximum
    set_count(7'd127);
    send_word(MODE_RUN, 6'd0, 6'd0);

    for (int p = 0; p < 12; p++) begin
      if (p == 5) n = 64;
      else if (p == 9) n = 2;
      else n = $urandom_range(2, 12);
      set_count(7'(n));
      idle_on = (p % 4 != 1);
      if (p == 3) hold_req = 1'b1;
      random_graph(n, 30);
    end

    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
+incdir+src
src/cgr_pkg.sv
src/cgr_dp.sv
src/cgr_ctrl.sv
src/chordal_graph_recognition.sv
sim/chordal_graph_recognition_tb.sv
